// File: hw/rtl/accel_motion_event_detector_core_macros.svh
// assertion helpers shared by the checker
`ifndef ACCEL_MOTION_EVENT_DETECTOR_CORE_MACROS_SVH
`define ACCEL_MOTION_EVENT_DETECTOR_CORE_MACROS_SVH

// checked on every rising edge outside reset
`define AMED_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define AMED_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/amed_pkg.sv
`timescale 1ns / 1ps

package amed_pkg;

	localparam int AXIS_W     = 16;
	localparam int TIME_W     = 32;
	localparam int MAG_W      = 16;
	localparam int SUM_W      = 2 * MAG_W;
	localparam int COUNT_W    = 32;
	localparam int CFG_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int IN_DATA_W  = 3 * AXIS_W + TIME_W;
	localparam int OUT_DATA_W = 2 * MAG_W + COUNT_W;
	localparam int OUT_USER_W = 2;
	localparam int BIT_CNT_W  = $clog2(MAG_W);

	localparam logic [MAG_W-1:0]     THRESHOLD_RESET = 16'd4915;
	localparam logic [TIME_W-1:0]    COOLDOWN_RESET  = 32'd1000;
	localparam logic [BIT_CNT_W-1:0] BIT_LAST        = BIT_CNT_W'(MAG_W - 1);

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN  = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_START,
		ST_ROOT,
		ST_FINISH
	} state_t;

endpackage

// File: hw/rtl/accel_motion_event_detector_core.sv
`timescale 1ns / 1ps

// channel     dir  payload                                          request when
// s_axis      in   tdata: accel_x, accel_y, accel_z, time_ms        tvalid & tready
// m_axis      out  tdata: magnitude, change, event_count;           tvalid & tready
//                  tuser: primed, motion
// cfg         in   cfg_index 0 change_threshold, 1 cooldown         cfg_we
//
// from accept to result register: shift-add squaring, a root load, the root
// bits plus their done step, and a decision that loads the result register once it is free;
// a new request is taken the cycle after that load
// the input takes a new request once the result is in the output register,
// so a stalled result does not hold up the next sample's squaring
// arst_n clears the sample history, event count and registers to defaults
module accel_motion_event_detector_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// slave side
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// tdata: accel_x [15:0], accel_y [31:16], accel_z [47:32], time_ms [79:48]
	input  logic [amed_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// master side
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// tdata: magnitude [15:0], change [31:16], event_count [63:32]
	output logic [amed_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// tuser: primed [0], motion [1]
	output logic [amed_pkg::OUT_USER_W-1:0] m_axis_tuser,
	// configuration writes
	input  logic                            cfg_we,
	input  logic [amed_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [amed_pkg::CFG_W-1:0]      cfg_wdata
);
	import amed_pkg::*;

	// control
	state_t               state_q;
	state_t               state_nx;
	logic [BIT_CNT_W-1:0] sq_cnt_q;
	logic                 sq_run;
	logic                 root_start;
	logic                 root_done;
	logic                 out_load;

	// sample being worked on
	logic [AXIS_W-1:0] ax_q, ay_q, az_q;   // absolute axis values
	logic [AXIS_W-1:0] bx_q, by_q, bz_q;   // multiplier bits, msb first
	logic [TIME_W-1:0] time_q;
	logic [SUM_W-1:0]  acc_q;

	// history and settings
	logic [MAG_W-1:0]   prev_mag_q;
	logic               has_prev_q;
	logic [COUNT_W-1:0] events_q;
	logic [TIME_W-1:0]  last_evt_q;
	logic [MAG_W-1:0]   thresh_q;
	logic [TIME_W-1:0]  cool_q;

	// result register
	logic               out_valid_q;
	logic [MAG_W-1:0]   out_mag_q;
	logic [MAG_W-1:0]   out_chg_q;
	logic               out_primed_q;
	logic               out_motion_q;
	logic [COUNT_W-1:0] out_cnt_q;

	// input unpacking
	logic [AXIS_W-1:0] in_x, in_y, in_z;
	logic [AXIS_W-1:0] abs_x, abs_y, abs_z;
	logic [TIME_W-1:0] in_time;

	assign in_x    = s_axis_tdata[AXIS_W-1:0];
	assign in_y    = s_axis_tdata[2*AXIS_W-1:AXIS_W];
	assign in_z    = s_axis_tdata[3*AXIS_W-1:2*AXIS_W];
	assign in_time = s_axis_tdata[IN_DATA_W-1:3*AXIS_W];

	// two's complement magnitude, -32768 maps to 32768
	assign abs_x = in_x[AXIS_W-1] ? (~in_x + 1'b1) : in_x;
	assign abs_y = in_y[AXIS_W-1] ? (~in_y + 1'b1) : in_y;
	assign abs_z = in_z[AXIS_W-1] ? (~in_z + 1'b1) : in_z;

	// one partial product row per axis, summed into the running square sum
	logic [AXIS_W+1:0] pp_sum;
	assign pp_sum = (bx_q[AXIS_W-1] ? {2'b00, ax_q} : '0)
	              + (by_q[AXIS_W-1] ? {2'b00, ay_q} : '0)
	              + (bz_q[AXIS_W-1] ? {2'b00, az_q} : '0);

	// decision on the finished magnitude
	logic [MAG_W-1:0]  mag;
	logic [MAG_W-1:0]  diff;
	logic [TIME_W-1:0] elapsed;
	logic              fire;

	assign diff    = (mag >= prev_mag_q) ? (mag - prev_mag_q) : (prev_mag_q - mag);
	assign elapsed = time_q - last_evt_q;
	assign fire    = has_prev_q && (diff > thresh_q) && (elapsed > cool_q);

	amed_root u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (acc_q),
		.done     (root_done),
		.root     (mag)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_axis_tvalid) state_nx = ST_SQUARE;
			ST_SQUARE: if (sq_cnt_q == BIT_LAST) state_nx = ST_START;
			ST_START:  state_nx = ST_ROOT;
			ST_ROOT:   if (root_done) state_nx = ST_FINISH;
			ST_FINISH: if (out_load) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_axis_tready = 1'b0;
		sq_run        = 1'b0;
		root_start    = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_axis_tready = 1'b1;
			ST_SQUARE: sq_run = 1'b1;
			ST_START:  root_start = 1'b1;
			ST_ROOT:   ;
			ST_FINISH: out_load = !out_valid_q || m_axis_tready;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sq_cnt_q    <= '0;
			out_valid_q <= 1'b0;
			prev_mag_q  <= '0;
			has_prev_q  <= 1'b0;
			events_q    <= '0;
			last_evt_q  <= '0;
			thresh_q    <= THRESHOLD_RESET;
			cool_q      <= COOLDOWN_RESET;
		end else begin
			state_q <= state_nx;

			if (sq_run) begin
				sq_cnt_q <= sq_cnt_q + 1'b1;
			end else begin
				sq_cnt_q <= '0;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			// history update once the result is committed
			if (out_load) begin
				prev_mag_q <= mag;
				has_prev_q <= 1'b1;
				if (fire) begin
					events_q   <= events_q + 1'b1;
					last_evt_q <= time_q;
				end
			end

			if (cfg_we) begin
				unique case (cfg_index)
					REG_THRESHOLD: thresh_q <= cfg_wdata[MAG_W-1:0];
					REG_COOLDOWN:  cool_q   <= cfg_wdata[TIME_W-1:0];
					default:       ;
				endcase
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ax_q   <= abs_x;
			ay_q   <= abs_y;
			az_q   <= abs_z;
			bx_q   <= abs_x;
			by_q   <= abs_y;
			bz_q   <= abs_z;
			time_q <= in_time;
			acc_q  <= '0;
		end else if (sq_run) begin
			// msb-first shift-add: acc = 2*acc + row
			bx_q  <= {bx_q[AXIS_W-2:0], 1'b0};
			by_q  <= {by_q[AXIS_W-2:0], 1'b0};
			bz_q  <= {bz_q[AXIS_W-2:0], 1'b0};
			acc_q <= {acc_q[SUM_W-2:0], 1'b0} + SUM_W'(pp_sum);
		end

		if (out_load) begin
			out_mag_q    <= mag;
			out_chg_q    <= has_prev_q ? diff : '0;
			out_primed_q <= has_prev_q;
			out_motion_q <= fire;
			out_cnt_q    <= fire ? (events_q + 1'b1) : events_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_cnt_q, out_chg_q, out_mag_q};
	assign m_axis_tuser  = {out_motion_q, out_primed_q};

endmodule

// File: hw/rtl/amed_root.sv
`timescale 1ns / 1ps

// bit-serial floor square root, one result bit per cycle
module amed_root (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [amed_pkg::SUM_W-1:0] radicand,
	output logic                      done,
	output logic [amed_pkg::MAG_W-1:0] root
);
	import amed_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [BIT_CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]     rad_q;
	logic [MAG_W:0]       rem_q;
	logic [MAG_W-1:0]     root_q;

	logic [MAG_W+2:0] rem_sh;
	logic [MAG_W+2:0] trial;
	logic [MAG_W+2:0] rem_sub;
	logic             take;

	assign rem_sh  = {rem_q, rad_q[SUM_W-1 -: 2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign take    = (rem_sh >= trial);
	assign rem_sub = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == BIT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[SUM_W-3:0], 2'b00};
			if (take) begin
				rem_q  <= rem_sub[MAG_W:0];
				root_q <= {root_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[MAG_W:0];
				root_q <= {root_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: hw/rtl/amed_checker.sv
`timescale 1ns / 1ps
`include "accel_motion_event_detector_core_macros.svh"

module amed_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [amed_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [amed_pkg::OUT_USER_W-1:0] m_axis_tuser
);

	// a stalled result keeps its payload
	`AMED_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

	// an event needs a previous magnitude
	`AMED_ASSERT(a_motion_primed, m_axis_tvalid |-> !(m_axis_tuser[1] && !m_axis_tuser[0]), "motion without history")

	// a priming result reports no change
	`AMED_ASSERT(a_prime_zero, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[31:16] == 16'd0, "nonzero change on priming sample")

	// input closes for the serial work after each request
	`AMED_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input open during serial work")

	// nothing offered while reset is held
	`AMED_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_axis_tvalid, "result valid in reset")

endmodule

bind accel_motion_event_detector_core amed_checker u_amed_checker (.*);
